/* src/ncl_pkg.sv */
package ncl_pkg;

    // Table size and coordinate precision.
    localparam int MAX_CLUSTERS = 8;
    localparam int COORD_BITS   = 16;

    // Fixed widths of the stream fields.
    localparam int IN_COORD_W = 16;
    localparam int ENTRY_W    = 3;
    localparam int LABEL_W    = 3;

    // Derived widths.
    localparam int IDX_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = SQ_W + 1;
    localparam int ENTRY_DATA_W = 2 * COORD_BITS;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int CLUSTERS_W = 4;
    localparam int LIMIT_W    = 16;
    localparam int LIM2_W     = 2 * LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

    // Command codes carried on tuser.
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Tag that travels alongside each centroid through the distance pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } ncl_tag_t;

    // Sign-extend a stream coordinate to the internal coordinate width.
    function automatic logic signed [COORD_BITS-1:0] sext_coord(
        input logic signed [IN_COORD_W-1:0] v
    );
        return COORD_BITS'(v);
    endfunction

endpackage

/* src/nearest_centroid_labeler.sv */
// Channel   Direction  Fields
// s_        in         tuser=cmd, tdata=entry_index/coord_x/coord_y, tlast=last_point
// m_        out        tdata=label/is_outlier, tlast=batch_end
// cfg_      in         register write: clusters_in_use (0), outlier_limit (1)
//
// A classify request sends n centroids, one per cycle, through the shared distance unit,
// n being clusters_in_use saturated to the table size (none when n is zero); each passes
// the registered table read and three distance stages, followed by the compare and the
// result hand-off.
// Reset is synchronous and active low; the centroid table is not cleared.
// A stalled result is held in the output register while the next request is taken.
module nearest_centroid_labeler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [39:0]                         s_tdata,   // entry_index, coord_x, coord_y, pad
    input  logic                                s_tuser,   // cmd
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // label, is_outlier, pad
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [ncl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ncl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int CB    = ncl_pkg::COORD_BITS;
    localparam int IDX_W = ncl_pkg::IDX_W;
    localparam int CNT_W = ncl_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [ncl_pkg::CLUSTERS_W-1:0]   clusters_reg;
    logic [ncl_pkg::LIMIT_W-1:0]      limit_reg;
    logic [ncl_pkg::LIM2_W-1:0]       lim2_reg;
    logic [CNT_W-1:0]                 n_reg, n_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             found_reg, found_next;
    logic [IDX_W-1:0]                 best_idx_reg, best_idx_next;
    logic [ncl_pkg::DIST_W-1:0]       best_d_reg, best_d_next;
    logic signed [CB-1:0]             px_reg;
    logic signed [CB-1:0]             py_reg;
    logic                             last_reg;
    ncl_pkg::ncl_tag_t                rd_tag_reg, rd_tag_next;
    logic                             m_valid_reg, m_valid_next;
    logic [ncl_pkg::LABEL_W-1:0]      m_label_reg;
    logic                             m_outlier_reg;
    logic                             m_last_reg;

    logic                             s_accept;
    logic                             cmd;
    logic [ncl_pkg::ENTRY_W-1:0]      entry_index;
    logic signed [CB-1:0]             in_x;
    logic signed [CB-1:0]             in_y;
    logic [CNT_W-1:0]                 n_sat;
    logic                             ram_we;
    logic [ncl_pkg::ENTRY_DATA_W-1:0] ram_rdata;
    ncl_pkg::ncl_tag_t                d_tag;
    logic [ncl_pkg::DIST_W-1:0]       d_val;
    logic                             issue;
    logic                             out_load;
    logic                             outlier;

    // Unpack the input request.
    assign cmd         = s_tuser;
    assign entry_index = s_tdata[2:0];
    assign in_x        = ncl_pkg::sext_coord(s_tdata[18:3]);
    assign in_y        = ncl_pkg::sext_coord(s_tdata[34:19]);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Clusters in use, saturated to the table size.
    assign n_sat = (32'(clusters_reg) > ncl_pkg::MAX_CLUSTERS)
                 ? CNT_W'(ncl_pkg::MAX_CLUSTERS) : CNT_W'(clusters_reg);

    // Configuration registers and the squared limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clusters_reg <= '0;
            limit_reg    <= ncl_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ncl_pkg::REG_CLUSTERS: clusters_reg <= cfg_wdata[ncl_pkg::CLUSTERS_W-1:0];
                ncl_pkg::REG_LIMIT:    limit_reg    <= cfg_wdata[ncl_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        lim2_reg <= ncl_pkg::LIM2_W'(limit_reg) * ncl_pkg::LIM2_W'(limit_reg);
    end

    // Centroid table: loads write, the scan reads one entry per cycle.
    assign ram_we = s_accept && (cmd == ncl_pkg::CMD_LOAD)
                 && (32'(entry_index) < ncl_pkg::MAX_CLUSTERS);

    ncl_ram #(
        .WIDTH (ncl_pkg::ENTRY_DATA_W),
        .DEPTH (ncl_pkg::MAX_CLUSTERS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (IDX_W'(entry_index)),
        .wdata ({in_y, in_x}),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    ncl_dist_unit u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (rd_tag_reg),
        .point_x  (px_reg),
        .point_y  (py_reg),
        .centroid (ram_rdata),
        .out_tag  (d_tag),
        .out_dist (d_val)
    );

    assign issue   = (state_reg == ST_SCAN) && (cnt_reg < n_reg);
    assign outlier = !found_reg || (best_d_reg > ncl_pkg::DIST_W'(lim2_reg));
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    // Sequencer: issue reads, track the running minimum, hand off the result.
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        m_valid_next  = m_valid_reg;

        rd_tag_next.valid = issue;
        rd_tag_next.last  = (cnt_reg == n_reg - CNT_W'(1));
        rd_tag_next.idx   = cnt_reg[IDX_W-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (cmd == ncl_pkg::CMD_CLASSIFY)) begin
                    n_next     = n_sat;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = (n_sat == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (d_tag.valid) begin
                    found_next = 1'b1;
                    if (!found_reg || (d_val < best_d_reg)) begin
                        best_d_next   = d_val;
                        best_idx_next = d_tag.idx;
                    end
                    if (d_tag.last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            rd_tag_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            rd_tag_reg  <= rd_tag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: point under test, running best, and the result.
    always_ff @(posedge aclk) begin
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        if (s_accept && (cmd == ncl_pkg::CMD_CLASSIFY)) begin
            px_reg   <= in_x;
            py_reg   <= in_y;
            last_reg <= s_tlast;
        end
        if (out_load) begin
            m_label_reg   <= outlier ? '0 : ncl_pkg::LABEL_W'(best_idx_reg);
            m_outlier_reg <= outlier;
            m_last_reg    <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_outlier_reg, m_label_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // A result appears only when the sequencer hands one off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the hand-off state");

    // The scan never reads past the entries in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= n_reg))
        else $error("scan counter ran past the clusters in use");

    // No new request is taken while distances are still in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (d_tag.valid || rd_tag_reg.valid) |-> !s_tready)
        else $error("request accepted during a scan");

    // An outlier always carries label zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[2:0] == 3'd0))
        else $error("outlier result with nonzero label");
`endif

endmodule

/* src/ncl_ram.sv */
module ncl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ncl_dist_unit.sv */
module ncl_dist_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  ncl_pkg::ncl_tag_t                        in_tag,
    input  logic signed [ncl_pkg::COORD_BITS-1:0]    point_x,
    input  logic signed [ncl_pkg::COORD_BITS-1:0]    point_y,
    input  logic [ncl_pkg::ENTRY_DATA_W-1:0]         centroid,
    output ncl_pkg::ncl_tag_t                        out_tag,
    output logic [ncl_pkg::DIST_W-1:0]               out_dist
);

    localparam int CB = ncl_pkg::COORD_BITS;

    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic signed [CB:0]   diff_x;
    logic signed [CB:0]   diff_y;
    logic [CB:0]          mag_x;
    logic [CB:0]          mag_y;

    logic [CB-1:0]                  abs_x_reg;
    logic [CB-1:0]                  abs_y_reg;
    logic [ncl_pkg::SQ_W-1:0]       sq_x_reg;
    logic [ncl_pkg::SQ_W-1:0]       sq_y_reg;
    logic [ncl_pkg::DIST_W-1:0]     dist_reg;
    ncl_pkg::ncl_tag_t              tag1_reg;
    ncl_pkg::ncl_tag_t              tag2_reg;
    ncl_pkg::ncl_tag_t              tag3_reg;

    assign cx = centroid[CB-1:0];
    assign cy = centroid[2*CB-1:CB];

    // Stage 1 input: signed differences and their magnitudes.
    always_comb begin
        diff_x = (CB+1)'(point_x) - (CB+1)'(cx);
        diff_y = (CB+1)'(point_y) - (CB+1)'(cy);
        mag_x  = diff_x[CB] ? (CB+1)'(-diff_x) : (CB+1)'(diff_x);
        mag_y  = diff_y[CB] ? (CB+1)'(-diff_y) : (CB+1)'(diff_y);
    end

    // Datapath: magnitude, square, then sum, one register after each.
    always_ff @(posedge aclk) begin
        abs_x_reg <= mag_x[CB-1:0];
        abs_y_reg <= mag_y[CB-1:0];
        sq_x_reg  <= ncl_pkg::SQ_W'(abs_x_reg) * ncl_pkg::SQ_W'(abs_x_reg);
        sq_y_reg  <= ncl_pkg::SQ_W'(abs_y_reg) * ncl_pkg::SQ_W'(abs_y_reg);
        dist_reg  <= ncl_pkg::DIST_W'(sq_x_reg) + ncl_pkg::DIST_W'(sq_y_reg);
    end

    // Tags follow the data so the sequencer knows which entry finished.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_tag  = tag3_reg;
    assign out_dist = dist_reg;

endmodule
